// ===== rtl/pbs_pkg.sv =====
package pbs_pkg;

  localparam int unsigned NODE_COUNT_DEF = 32;
  localparam int unsigned NODE_COUNT_MAX = 64;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned MV_W    = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned DVD_W   = 48;
  localparam int unsigned PROD_W  = 36;

  // Function codes on the input beat
  localparam logic [FUNC_W-1:0] FUNC_PKT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RPT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR = 2'd2;

  // Configuration register indexes
  localparam logic REG_LOW_THR  = 1'b0;
  localparam logic REG_EXPECTED = 1'b1;

  localparam logic [MV_W-1:0]  LOW_THR_RST  = 16'd3300;
  localparam logic [CNT_W-1:0] EXPECTED_RST = 32'd96;

  localparam logic [19:0] TENTHS_PER_DAY = 20'd864000;

  typedef enum logic [1:0] {
    CMD_PKT,
    CMD_RPT,
    CMD_CLR
  } cmd_e;

  typedef struct packed {
    cmd_e             op;
    logic [ID_W-1:0]  id;
    logic [TS_W-1:0]  ts;
    logic [MV_W-1:0]  mv;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [TS_W-1:0]  t0;
    logic [TS_W-1:0]  t1;
    logic [MV_W-1:0]  v0;
    logic [MV_W-1:0]  v1;
    logic [SUM_W-1:0] sum;
  } row_t;

endpackage

// ===== rtl/pbs_front.sv =====
module pbs_front import pbs_pkg::*; #(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [ID_W-1:0]   node_id_i,
  input  logic [TS_W-1:0]   timestamp_s_i,
  input  logic [MV_W-1:0]   battery_mv_i,
  output logic              cmd_vld_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  localparam int unsigned DEPTH = 2;

  cmd_t       q_mem [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       keep;
  logic       acc;
  logic       pop;
  cmd_t       cmd_new;

  // Classify the beat: drop unused codes and packet beats with out-of-range ids
  always_comb begin
    cmd_new.id = node_id_i;
    cmd_new.ts = timestamp_s_i;
    cmd_new.mv = battery_mv_i;
    cmd_new.op = CMD_PKT;
    keep       = 1'b0;
    unique case (func_i)
      FUNC_PKT: begin
        cmd_new.op = CMD_PKT;
        keep       = node_id_i < ID_W'(NODE_COUNT);
      end
      FUNC_RPT: begin
        cmd_new.op = CMD_RPT;
        keep       = 1'b1;
      end
      FUNC_CLR: begin
        cmd_new.op = CMD_CLR;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = cnt_q == 2'(DEPTH);
  assign acc       = push && !full && keep;
  assign cmd_vld_o = cnt_q != 2'd0;
  assign pop       = cmd_pop_i && cmd_vld_o;
  assign cmd_o     = q_mem[rd_ptr_q];

  // Store classified commands
  always_ff @(posedge clk_i) begin
    if (acc) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (acc) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(pop);
    end
  end

endmodule

// ===== rtl/pbs_div.sv =====
module pbs_div import pbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q, dvs_q;
  logic [DVD_W-1:0]  quo_q;
  logic [CNT_W:0]    shf;
  logic              ge;

  // One restoring step per cycle
  assign shf = {rem_q, quo_q[DVD_W-1]};
  assign ge  = shf >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? CNT_W'(shf - {1'b0, dvs_q}) : CNT_W'(shf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/pbs_back.sv =====
module pbs_back import pbs_pkg::*; #(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_vld_i,
  input  cmd_t                     cmd_i,
  output logic                     cmd_pop_o,
  input  logic [MV_W-1:0]          low_thr_i,
  input  logic [CNT_W-1:0]         expected_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [IDX_W-1:0]         node_index_o,
  output logic                     has_data_o,
  output logic [CNT_W-1:0]         packet_count_o,
  output logic [MV_W-1:0]          mean_mv_o,
  output logic signed [31:0]       slope_tenth_mv_per_day_o,
  output logic                     missing_flag_o,
  output logic                     low_flag_o,
  output logic                     last_of_report_o
);

  localparam int unsigned SLOT_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PKT   = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_MEAN  = 3'd3;
  localparam logic [2:0] ST_SLOPE = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  row_t                  mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] vld_q;
  row_t                  rd_data_q;
  logic                  rd_vld_q;
  logic                  rd_en, wr_en;
  logic [SLOT_W-1:0]     rd_addr;
  row_t                  row, row_new;

  logic [2:0]            st_q, st_d;
  cmd_t                  cmd_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [DVD_W-1:0]      prod_q;
  logic [SUM_W-1:0]      lowprod_q;
  logic [MV_W-1:0]       mean_q;
  logic [31:0]           slope_q, slope_sat;
  logic                  neg;
  logic [MV_W-1:0]       mag;
  logic                  dv_start, dv_done;
  logic [DVD_W-1:0]      dv_dvd, dv_quot;
  logic [CNT_W-1:0]      dv_dvs;
  logic                  out_vld_q, out_load, last_slot;

  assign row       = rd_vld_q ? rd_data_q : '0;
  assign last_slot = slot_q == SLOT_W'(NODE_COUNT - 1);
  assign neg       = row.v1 < row.v0;
  assign mag       = neg ? row.v0 - row.v1 : row.v1 - row.v0;
  assign out_load  = (st_q == ST_EMIT) && (!out_vld_q || pop);

  // Packet update of one row
  always_comb begin
    row_new    = row;
    if (row.cnt == '0) begin
      row_new.t0 = cmd_q.ts;
      row_new.v0 = cmd_q.mv;
    end
    row_new.t1 = cmd_q.ts;
    row_new.v1 = cmd_q.mv;
    if (row.cnt != '1) begin
      row_new.sum = row.sum + SUM_W'(cmd_q.mv);
      row_new.cnt = row.cnt + 1'b1;
    end
  end

  // Saturate the slope quotient
  always_comb begin
    if (neg) begin
      slope_sat = (dv_quot >= DVD_W'(32'h8000_0000)) ? 32'h8000_0000
                                                     : 32'(0 - dv_quot[31:0]);
    end else begin
      slope_sat = (dv_quot > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                    : dv_quot[31:0];
    end
  end

  // Sequencer
  always_comb begin
    st_d      = st_q;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = slot_q;
    wr_en     = 1'b0;
    dv_start  = 1'b0;
    dv_dvd    = DVD_W'(row.sum);
    dv_dvs    = row.cnt;
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            CMD_PKT: begin
              rd_en   = 1'b1;
              rd_addr = cmd_i.id[SLOT_W-1:0];
              st_d    = ST_PKT;
            end
            CMD_RPT: begin
              rd_en   = 1'b1;
              rd_addr = '0;
              st_d    = ST_RD;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_PKT: begin
        wr_en = 1'b1;
        st_d  = ST_IDLE;
      end
      ST_RD: begin
        dv_start = 1'b1;
        st_d     = ST_MEAN;
      end
      ST_MEAN: begin
        if (dv_done) begin
          dv_start = 1'b1;
          dv_dvd   = prod_q;
          dv_dvs   = row.t1 - row.t0;
          st_d     = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (dv_done) st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          if (last_slot) begin
            st_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot_q + 1'b1;
            st_d    = ST_RD;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  pbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dvd),
    .divisor_i  (dv_dvs),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  // Row memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cmd_q.id[SLOT_W-1:0]] <= row_new;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  // Hold command, products and partial results
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (st_q == ST_RD) begin
      prod_q    <= DVD_W'(PROD_W'(mag) * PROD_W'(TENTHS_PER_DAY));
      lowprod_q <= SUM_W'(low_thr_i) * SUM_W'(row.cnt);
    end
    if (st_q == ST_MEAN && dv_done) mean_q <= dv_quot[MV_W-1:0];
    if (st_q == ST_SLOPE && dv_done) slope_q <= slope_sat;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      node_index_o             <= IDX_W'(slot_q);
      has_data_o               <= row.cnt != '0;
      packet_count_o           <= row.cnt;
      mean_mv_o                <= (row.cnt != '0) ? mean_q : '0;
      slope_tenth_mv_per_day_o <= (row.cnt != '0 && row.t1 > row.t0) ? slope_q : '0;
      missing_flag_o           <= row.cnt < expected_i;
      low_flag_o               <= row.sum < lowprod_q;
      last_of_report_o         <= last_slot;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      slot_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
        slot_q   <= (st_q == ST_PKT || cmd_pop_o) ? '0 : rd_addr;
      end
      if (wr_en) vld_q[cmd_q.id[SLOT_W-1:0]] <= 1'b1;
      if (cmd_pop_o && cmd_i.op == CMD_CLR) vld_q <= '0;
      if (out_load) out_vld_q <= 1'b1;
      else if (pop) out_vld_q <= 1'b0;
    end
  end

  assign empty = !out_vld_q;

endmodule

// ===== rtl/per_node_battery_statistics.sv =====
// Packet beat: queued in the front; the back reads the row, then writes it back.
// Clear beat: taken in the idle state of the back. Report beat: one line per slot,
// its mean and slope from the shared one-bit-per-cycle divider (48 steps for
// the mean, 48 for the slope). Up to 2 commands wait between front and back.
// Reset (rst_ni low, asynchronous) empties the table, queues and output.
module per_node_battery_statistics import pbs_pkg::*; #(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [ID_W-1:0]    node_id_i,
  input  logic [TS_W-1:0]    timestamp_s_i,
  input  logic [MV_W-1:0]    battery_mv_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  output logic               empty,
  input  logic               pop,
  output logic [IDX_W-1:0]   node_index_o,
  output logic               has_data_o,
  output logic [CNT_W-1:0]   packet_count_o,
  output logic [MV_W-1:0]    mean_mv_o,
  output logic signed [31:0] slope_tenth_mv_per_day_o,
  output logic               missing_flag_o,
  output logic               low_flag_o,
  output logic               last_of_report_o
);

  logic [MV_W-1:0]  low_thr_q;
  logic [CNT_W-1:0] expected_q;
  logic             cmd_vld, cmd_pop;
  cmd_t             cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RST;
      expected_q <= EXPECTED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOW_THR:  low_thr_q  <= cfg_data_i[MV_W-1:0];
        REG_EXPECTED: expected_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pbs_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .node_id_i     (node_id_i),
    .timestamp_s_i (timestamp_s_i),
    .battery_mv_i  (battery_mv_i),
    .cmd_vld_o     (cmd_vld),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  pbs_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cmd_vld_i                (cmd_vld),
    .cmd_i                    (cmd),
    .cmd_pop_o                (cmd_pop),
    .low_thr_i                (low_thr_q),
    .expected_i               (expected_q),
    .empty                    (empty),
    .pop                      (pop),
    .node_index_o             (node_index_o),
    .has_data_o               (has_data_o),
    .packet_count_o           (packet_count_o),
    .mean_mv_o                (mean_mv_o),
    .slope_tenth_mv_per_day_o (slope_tenth_mv_per_day_o),
    .missing_flag_o           (missing_flag_o),
    .low_flag_o               (low_flag_o),
    .last_of_report_o         (last_of_report_o)
  );

endmodule
